### hdl/sarp_pkg.sv
// ----------------------------------------------------------------------------
// sarp_pkg
// Shared widths, constants, register codes and types of the servo ramp block.
// ----------------------------------------------------------------------------
package sarp_pkg;

   localparam int ANG_W       = 17;
   localparam int PWM_W       = 16;
   localparam int DUR_W       = 16;
   localparam int ACC_W       = 32;
   localparam int TICK_W      = 13;
   localparam int LIM_W       = ANG_W + 8;
   localparam int SPAN_W      = LIM_W + 1;
   localparam int DPWM_W      = PWM_W + 1;
   localparam int PROD_W      = SPAN_W + DPWM_W;

   localparam int DVD_W       = 41;
   localparam int DIV_W       = 25;
   localparam int QUO_W       = 33;
   localparam int SHORT_ITER  = 16;
   localparam int LONG_ITER   = 33;
   localparam int CNT_W       = 6;

   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 17;
   localparam int NUM_REGS    = 8;

   localparam int TICK_MS_DEF = 10;

   localparam logic [TICK_W-1:0] TICKS_MAX     = 13'd8191;
   localparam int                JUMP_STEP     = 3 * 65536;
   localparam int                ANGLE_OUT_MAX = 46080;

   localparam logic [2:0] REG_UP_MIN_ANGLE   = 3'd0;
   localparam logic [2:0] REG_UP_MAX_ANGLE   = 3'd1;
   localparam logic [2:0] REG_UP_MIN_PWM     = 3'd2;
   localparam logic [2:0] REG_UP_MAX_PWM     = 3'd3;
   localparam logic [2:0] REG_DOWN_MIN_ANGLE = 3'd4;
   localparam logic [2:0] REG_DOWN_MAX_ANGLE = 3'd5;
   localparam logic [2:0] REG_DOWN_MIN_PWM   = 3'd6;
   localparam logic [2:0] REG_DOWN_MAX_PWM   = 3'd7;

   localparam logic signed [ANG_W-1:0] RST_MIN_ANGLE = -17'sd23040;
   localparam logic signed [ANG_W-1:0] RST_MAX_ANGLE = 17'sd23040;
   localparam logic [PWM_W-1:0]        RST_MIN_PWM   = 16'd500;
   localparam logic [PWM_W-1:0]        RST_MAX_PWM   = 16'd2500;

   typedef struct packed {
      logic signed [ANG_W-1:0] min_angle;
      logic signed [ANG_W-1:0] max_angle;
      logic [PWM_W-1:0]        min_pwm;
      logic [PWM_W-1:0]        max_pwm;
   } lim_type;

   typedef struct packed {
      logic start;
      logic long_mode;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic rem_nz;
   } div_sts_type;

endpackage

### hdl/sarp_regs.sv
// ----------------------------------------------------------------------------
// sarp_regs
// Per-axis angle limit and PWM range registers with axis select.
// ----------------------------------------------------------------------------
module sarp_regs (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [sarp_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [sarp_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                sel_axis,
   output sarp_pkg::lim_type                   lim
);

   sarp_pkg::lim_type up_ff;
   sarp_pkg::lim_type up_in;
   sarp_pkg::lim_type down_ff;
   sarp_pkg::lim_type down_in;

   always_comb begin
      up_in   = up_ff;
      down_in = down_ff;
      if (csr_wr_en && (csr_addr < sarp_pkg::CSR_ADDR_W'(sarp_pkg::NUM_REGS))) begin
         case (csr_addr[2:0])
            sarp_pkg::REG_UP_MIN_ANGLE:   up_in.min_angle   = csr_wdata;
            sarp_pkg::REG_UP_MAX_ANGLE:   up_in.max_angle   = csr_wdata;
            sarp_pkg::REG_UP_MIN_PWM:     up_in.min_pwm     = csr_wdata[15:0];
            sarp_pkg::REG_UP_MAX_PWM:     up_in.max_pwm     = csr_wdata[15:0];
            sarp_pkg::REG_DOWN_MIN_ANGLE: down_in.min_angle = csr_wdata;
            sarp_pkg::REG_DOWN_MAX_ANGLE: down_in.max_angle = csr_wdata;
            sarp_pkg::REG_DOWN_MIN_PWM:   down_in.min_pwm   = csr_wdata[15:0];
            sarp_pkg::REG_DOWN_MAX_PWM:   down_in.max_pwm   = csr_wdata[15:0];
            default: begin
               up_in   = up_ff;
               down_in = down_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         up_ff.min_angle   <= sarp_pkg::RST_MIN_ANGLE;
         up_ff.max_angle   <= sarp_pkg::RST_MAX_ANGLE;
         up_ff.min_pwm     <= sarp_pkg::RST_MIN_PWM;
         up_ff.max_pwm     <= sarp_pkg::RST_MAX_PWM;
         down_ff.min_angle <= sarp_pkg::RST_MIN_ANGLE;
         down_ff.max_angle <= sarp_pkg::RST_MAX_ANGLE;
         down_ff.min_pwm   <= sarp_pkg::RST_MIN_PWM;
         down_ff.max_pwm   <= sarp_pkg::RST_MAX_PWM;
      end else begin
         up_ff   <= up_in;
         down_ff <= down_in;
      end
   end

   assign lim = sel_axis ? down_ff : up_ff;

endmodule

### hdl/sarp_div.sv
// ----------------------------------------------------------------------------
// sarp_div
// Shared restoring divider, one quotient bit per cycle, short or long run.
// ----------------------------------------------------------------------------
module sarp_div (
   input  logic                            clock,
   input  logic                            reset,
   input  sarp_pkg::div_ctl_type           ctl,
   input  logic [sarp_pkg::DVD_W-1:0]      dividend,
   input  logic [sarp_pkg::DIV_W-1:0]      divisor,
   output sarp_pkg::div_sts_type           sts,
   output logic [sarp_pkg::QUO_W-1:0]      quotient
);

   logic [sarp_pkg::DIV_W-1:0] rem_ff;
   logic [sarp_pkg::DIV_W-1:0] rem_in;
   logic [sarp_pkg::QUO_W-1:0] quo_ff;
   logic [sarp_pkg::QUO_W-1:0] quo_in;
   logic [sarp_pkg::DIV_W-1:0] dvs_ff;
   logic [sarp_pkg::DIV_W-1:0] dvs_in;
   logic [sarp_pkg::CNT_W-1:0] cnt_ff;
   logic [sarp_pkg::CNT_W-1:0] cnt_in;
   logic                       busy_ff;
   logic                       busy_in;
   logic                       done_ff;
   logic                       done_in;

   logic [sarp_pkg::DIV_W:0]   shifted;
   logic [sarp_pkg::DIV_W:0]   diff;
   logic                       ge;

   always_comb begin
      shifted = {rem_ff, quo_ff[sarp_pkg::QUO_W-1]};
      diff    = shifted - {1'b0, dvs_ff};
      ge      = shifted >= {1'b0, dvs_ff};

      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (ctl.start) begin
         dvs_in  = divisor;
         busy_in = 1'b1;
         if (ctl.long_mode) begin
            rem_in = '0;
            quo_in = dividend[sarp_pkg::QUO_W-1:0];
            cnt_in = sarp_pkg::CNT_W'(sarp_pkg::LONG_ITER);
         end else begin
            rem_in = dividend[sarp_pkg::DVD_W-1:sarp_pkg::SHORT_ITER];
            quo_in = {dividend[sarp_pkg::SHORT_ITER-1:0],
                      (sarp_pkg::QUO_W - sarp_pkg::SHORT_ITER)'(0)};
            cnt_in = sarp_pkg::CNT_W'(sarp_pkg::SHORT_ITER);
         end
      end else if (busy_ff) begin
         rem_in = ge ? diff[sarp_pkg::DIV_W-1:0] : shifted[sarp_pkg::DIV_W-1:0];
         quo_in = {quo_ff[sarp_pkg::QUO_W-2:0], ge};
         cnt_in = cnt_ff - sarp_pkg::CNT_W'(1);
         if (cnt_ff == sarp_pkg::CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign sts.busy   = busy_ff;
   assign sts.done   = done_ff;
   assign sts.rem_nz = rem_ff != '0;
   assign quotient   = quo_ff;

endmodule

### hdl/servo_angle_ramp_pwm.sv
// ----------------------------------------------------------------------------
// servo_angle_ramp_pwm
// Two-axis pan/tilt servo ramp generator with per-axis PWM mapping.
// ----------------------------------------------------------------------------
// The req channel takes a move command (axis, target angle, duration) or a
// tick. A move computes the tick count and per-tick step on the shared serial
// divider; a positive step above three degrees jumps the axis to its target
// and gives one rsp transaction, otherwise the ramp is stored and nothing is
// returned. A tick advances each axis with ticks left, axis 0 first, and
// gives one rsp transaction per axis moved; rsp_last marks the final one.
// Each PWM value takes a clamp, a multiply and a 16-bit run of the divider,
// which is skipped when the angle range is zero. A move runs the divider
// twice, a short run for the tick count and a long run for the step.
// req_ready is high only while the sequencer is idle. A single output
// register holds the last result, so a new transaction is taken while it
// waits; a stalled rsp_ready holds the sequencer before its next result.
// Reset clears angles, ramps and rsp_valid and loads the default limits; the
// user must make csr writes only while the block is idle; it is not enforced.
// ----------------------------------------------------------------------------
module servo_angle_ramp_pwm #(
   parameter int TICK_MS = sarp_pkg::TICK_MS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_type,
   input  logic                                   req_axis,
   input  logic signed [sarp_pkg::ANG_W-1:0]      req_target_angle,
   input  logic [sarp_pkg::DUR_W-1:0]             req_duration_ms,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic                                   rsp_out_axis,
   output logic [sarp_pkg::PWM_W-1:0]             rsp_pwm_value,
   output logic signed [sarp_pkg::ANG_W-1:0]      rsp_angle_now,
   output logic                                   rsp_last,
   input  logic                                   csr_wr_en,
   input  logic [sarp_pkg::CSR_ADDR_W-1:0]        csr_addr,
   input  logic [sarp_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   typedef enum logic [10:0] {
      ST_IDLE    = 11'b000_0000_0001,
      ST_TK_GO   = 11'b000_0000_0010,
      ST_TK_WAIT = 11'b000_0000_0100,
      ST_ST_GO   = 11'b000_0000_1000,
      ST_ST_WAIT = 11'b000_0001_0000,
      ST_ADV     = 11'b000_0010_0000,
      ST_CLAMP   = 11'b000_0100_0000,
      ST_MUL     = 11'b000_1000_0000,
      ST_PW_GO   = 11'b001_0000_0000,
      ST_PW_WAIT = 11'b010_0000_0000,
      ST_EMIT    = 11'b100_0000_0000
   } state_type;

   localparam int ACC_W  = sarp_pkg::ACC_W;
   localparam int LIM_W  = sarp_pkg::LIM_W;
   localparam int SPAN_W = sarp_pkg::SPAN_W;
   localparam int PROD_W = sarp_pkg::PROD_W;
   localparam int QUO_W  = sarp_pkg::QUO_W;
   localparam int TICK_W = sarp_pkg::TICK_W;

   state_type                          state_ff;
   state_type                          state_in;
   logic                               is_tick_ff;
   logic                               is_tick_in;
   logic                               ax_ff;
   logic                               ax_in;
   logic signed [sarp_pkg::ANG_W-1:0]  tgt_ff;
   logic signed [sarp_pkg::ANG_W-1:0]  tgt_in;
   logic [sarp_pkg::DUR_W-1:0]         dur_ff;
   logic [sarp_pkg::DUR_W-1:0]         dur_in;
   logic [TICK_W-1:0]                  nticks_ff;
   logic [TICK_W-1:0]                  nticks_in;
   logic                               dneg_ff;
   logic                               dneg_in;
   logic signed [ACC_W-1:0]            cur_ff [2];
   logic signed [ACC_W-1:0]            cur_in [2];
   logic signed [ACC_W-1:0]            step_ff [2];
   logic signed [ACC_W-1:0]            step_in [2];
   logic [TICK_W-1:0]                  ticks_ff [2];
   logic [TICK_W-1:0]                  ticks_in [2];
   logic signed [SPAN_W-1:0]           diff_ff;
   logic signed [SPAN_W-1:0]           diff_in;
   logic signed [SPAN_W-1:0]           den_ff;
   logic signed [SPAN_W-1:0]           den_in;
   logic signed [sarp_pkg::DPWM_W-1:0] dp_ff;
   logic signed [sarp_pkg::DPWM_W-1:0] dp_in;
   logic signed [PROD_W-1:0]           prod_ff;
   logic signed [PROD_W-1:0]           prod_in;
   logic [sarp_pkg::PWM_W-1:0]         pwm_ff;
   logic [sarp_pkg::PWM_W-1:0]         pwm_in;

   logic                               rsp_valid_ff;
   logic                               rsp_valid_in;
   logic                               rsp_axis_ff;
   logic [sarp_pkg::PWM_W-1:0]         rsp_pwm_ff;
   logic signed [sarp_pkg::ANG_W-1:0]  rsp_ang_ff;
   logic                               rsp_last_ff;

   sarp_pkg::lim_type                  lim;
   sarp_pkg::div_ctl_type              div_ctl;
   sarp_pkg::div_sts_type              div_sts;
   logic [sarp_pkg::DVD_W-1:0]         div_dvd;
   logic [sarp_pkg::DIV_W-1:0]         div_dvs;
   logic [QUO_W-1:0]                   div_quo;

   logic                               req_fire;
   logic                               emit_fire;
   logic [sarp_pkg::DUR_W-1:0]         dur_eff;
   logic signed [ACC_W:0]              delta;
   logic [ACC_W:0]                     delta_mag;
   logic signed [QUO_W:0]              step_q;
   logic signed [ACC_W:0]              sum;
   logic signed [ACC_W-1:0]            sum_sat;
   logic signed [ACC_W-1:0]            a_cur;
   logic signed [LIM_W-1:0]            lo;
   logic signed [LIM_W-1:0]            hi;
   logic signed [ACC_W:0]              a_lo;
   logic [PROD_W-1:0]                  prod_mag;
   logic [SPAN_W-1:0]                  den_mag;
   logic                               pw_neg;
   logic signed [sarp_pkg::DPWM_W:0]   q_pw;
   logic signed [sarp_pkg::DPWM_W:0]   p_sum;
   logic signed [ACC_W-9:0]            ang_fl;
   logic signed [sarp_pkg::ANG_W-1:0]  ang_out;
   logic                               last_flag;

   sarp_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .sel_axis  (ax_ff),
      .lim       (lim)
   );

   sarp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .sts      (div_sts),
      .quotient (div_quo)
   );

   assign req_ready = state_ff == ST_IDLE;
   assign req_fire  = req_valid && req_ready;
   assign emit_fire = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      dur_eff   = (dur_ff < sarp_pkg::DUR_W'(TICK_MS)) ? sarp_pkg::DUR_W'(TICK_MS) : dur_ff;
      delta     = ((ACC_W + 1)'(tgt_ff) <<< 8) - (ACC_W + 1)'(cur_ff[ax_ff]);
      delta_mag = delta[ACC_W] ? (ACC_W + 1)'(0) - delta : delta;
      step_q    = dneg_ff ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
      sum       = (ACC_W + 1)'(cur_ff[ax_ff]) + (ACC_W + 1)'(step_ff[ax_ff]);
      if (sum[ACC_W] != sum[ACC_W-1]) begin
         sum_sat = sum[ACC_W] ? {1'b1, (ACC_W - 1)'(0)} : {1'b0, {(ACC_W - 1){1'b1}}};
      end else begin
         sum_sat = sum[ACC_W-1:0];
      end

      a_cur = cur_ff[ax_ff];
      lo    = {lim.min_angle, 8'd0};
      hi    = {lim.max_angle, 8'd0};
      a_lo  = (ACC_W + 1)'(a_cur) - (ACC_W + 1)'(lo);

      prod_mag = prod_ff[PROD_W-1] ? PROD_W'(0) - prod_ff : prod_ff;
      den_mag  = den_ff[SPAN_W-1] ? SPAN_W'(0) - den_ff : den_ff;
      pw_neg   = prod_ff[PROD_W-1] ^ den_ff[SPAN_W-1];
      if (pw_neg) begin
         q_pw = -$signed({2'b00, div_quo[15:0]}) - $signed({17'd0, div_sts.rem_nz});
      end else begin
         q_pw = $signed({2'b00, div_quo[15:0]});
      end
      p_sum = $signed({2'b00, lim.min_pwm}) + q_pw;

      ang_fl = cur_ff[ax_ff][ACC_W-1:8];
      if (ang_fl > (ACC_W - 8)'(sarp_pkg::ANGLE_OUT_MAX)) begin
         ang_out = sarp_pkg::ANG_W'(sarp_pkg::ANGLE_OUT_MAX);
      end else if (ang_fl < -(ACC_W - 8)'(sarp_pkg::ANGLE_OUT_MAX)) begin
         ang_out = -sarp_pkg::ANG_W'(sarp_pkg::ANGLE_OUT_MAX);
      end else begin
         ang_out = ang_fl[sarp_pkg::ANG_W-1:0];
      end
      last_flag = !is_tick_ff || ax_ff || (ticks_ff[1] == '0);
   end

   always_comb begin
      div_ctl = '0;
      div_dvd = '0;
      div_dvs = '0;
      case (state_ff)
         ST_TK_GO: begin
            div_ctl.start = 1'b1;
            div_dvd       = sarp_pkg::DVD_W'(dur_eff);
            div_dvs       = sarp_pkg::DIV_W'(TICK_MS);
         end
         ST_ST_GO: begin
            div_ctl.start     = 1'b1;
            div_ctl.long_mode = 1'b1;
            div_dvd           = sarp_pkg::DVD_W'(delta_mag);
            div_dvs           = sarp_pkg::DIV_W'(nticks_ff);
         end
         ST_PW_GO: begin
            div_ctl.start = den_ff != '0;
            div_dvd       = prod_mag[sarp_pkg::DVD_W-1:0];
            div_dvs       = den_mag[sarp_pkg::DIV_W-1:0];
         end
         default: begin
            div_ctl = '0;
         end
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      is_tick_in = is_tick_ff;
      ax_in      = ax_ff;
      tgt_in     = tgt_ff;
      dur_in     = dur_ff;
      nticks_in  = nticks_ff;
      dneg_in    = dneg_ff;
      cur_in     = cur_ff;
      step_in    = step_ff;
      ticks_in   = ticks_ff;
      diff_in    = diff_ff;
      den_in     = den_ff;
      dp_in      = dp_ff;
      prod_in    = prod_ff;
      pwm_in     = pwm_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               is_tick_in = req_type;
               ax_in      = req_type ? 1'b0 : req_axis;
               tgt_in     = req_target_angle;
               dur_in     = req_duration_ms;
               state_in   = req_type ? ST_ADV : ST_TK_GO;
            end
         end
         ST_TK_GO: begin
            state_in = ST_TK_WAIT;
         end
         ST_TK_WAIT: begin
            if (div_sts.done) begin
               nticks_in = (div_quo[15:0] > 16'(sarp_pkg::TICKS_MAX)) ?
                           sarp_pkg::TICKS_MAX : div_quo[TICK_W-1:0];
               state_in  = ST_ST_GO;
            end
         end
         ST_ST_GO: begin
            dneg_in  = delta[ACC_W];
            state_in = ST_ST_WAIT;
         end
         ST_ST_WAIT: begin
            if (div_sts.done) begin
               if (step_q > (QUO_W + 1)'(sarp_pkg::JUMP_STEP)) begin
                  cur_in[ax_ff]   = ACC_W'(tgt_ff) <<< 8;
                  step_in[ax_ff]  = '0;
                  ticks_in[ax_ff] = '0;
                  state_in        = ST_CLAMP;
               end else begin
                  if (step_q < -(QUO_W + 1)'(64'sh8000_0000)) begin
                     step_in[ax_ff] = {1'b1, (ACC_W - 1)'(0)};
                  end else begin
                     step_in[ax_ff] = step_q[ACC_W-1:0];
                  end
                  ticks_in[ax_ff] = nticks_ff;
                  state_in        = ST_IDLE;
               end
            end
         end
         ST_ADV: begin
            if (ticks_ff[ax_ff] != '0) begin
               cur_in[ax_ff]   = sum_sat;
               ticks_in[ax_ff] = ticks_ff[ax_ff] - TICK_W'(1);
               state_in        = ST_CLAMP;
            end else if (!ax_ff) begin
               ax_in = 1'b1;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_CLAMP: begin
            den_in = SPAN_W'(hi) - SPAN_W'(lo);
            dp_in  = $signed({1'b0, lim.max_pwm}) - $signed({1'b0, lim.min_pwm});
            if ((ACC_W + 1)'(a_cur) <= (ACC_W + 1)'(lo)) begin
               diff_in = '0;
            end else if ((ACC_W + 1)'(a_cur) >= (ACC_W + 1)'(hi)) begin
               diff_in = SPAN_W'(hi) - SPAN_W'(lo);
            end else begin
               diff_in = a_lo[SPAN_W-1:0];
            end
            state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in  = PROD_W'(diff_ff) * PROD_W'(dp_ff);
            state_in = ST_PW_GO;
         end
         ST_PW_GO: begin
            if (den_ff == '0) begin
               pwm_in   = lim.min_pwm;
               state_in = ST_EMIT;
            end else begin
               state_in = ST_PW_WAIT;
            end
         end
         ST_PW_WAIT: begin
            if (div_sts.done) begin
               if (p_sum < 0) begin
                  pwm_in = '0;
               end else if (p_sum > $signed(18'd65535)) begin
                  pwm_in = '1;
               end else begin
                  pwm_in = p_sum[sarp_pkg::PWM_W-1:0];
               end
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (emit_fire) begin
               if (is_tick_ff && !ax_ff) begin
                  ax_in    = 1'b1;
                  state_in = ST_ADV;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         is_tick_ff   <= 1'b0;
         ax_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cur_ff[0]    <= '0;
         cur_ff[1]    <= '0;
         step_ff[0]   <= '0;
         step_ff[1]   <= '0;
         ticks_ff[0]  <= '0;
         ticks_ff[1]  <= '0;
      end else begin
         state_ff     <= state_in;
         is_tick_ff   <= is_tick_in;
         ax_ff        <= ax_in;
         rsp_valid_ff <= rsp_valid_in;
         cur_ff       <= cur_in;
         step_ff      <= step_in;
         ticks_ff     <= ticks_in;
      end
      tgt_ff    <= tgt_in;
      dur_ff    <= dur_in;
      nticks_ff <= nticks_in;
      dneg_ff   <= dneg_in;
      diff_ff   <= diff_in;
      den_ff    <= den_in;
      dp_ff     <= dp_in;
      prod_ff   <= prod_in;
      pwm_ff    <= pwm_in;
      if (emit_fire) begin
         rsp_axis_ff <= ax_ff;
         rsp_pwm_ff  <= pwm_ff;
         rsp_ang_ff  <= ang_out;
         rsp_last_ff <= last_flag;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_axis  = rsp_axis_ff;
   assign rsp_pwm_value = rsp_pwm_ff;
   assign rsp_angle_now = rsp_ang_ff;
   assign rsp_last      = rsp_last_ff;

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_sts.done |-> (state_ff == ST_TK_WAIT || state_ff == ST_ST_WAIT ||
                        state_ff == ST_PW_WAIT))
      else $error("divider finished outside a wait state");

   a_jump_clears_ramp: assert property (@(posedge clock) disable iff (reset)
      (emit_fire && !is_tick_ff) |-> (ticks_ff[ax_ff] == '0 && step_ff[ax_ff] == '0))
      else $error("jump result with a live ramp");

   a_idle_div_free: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !div_sts.busy)
      else $error("ready while the divider is running");

   a_tick_last: assert property (@(posedge clock) disable iff (reset)
      (emit_fire && is_tick_ff && ax_ff) |-> last_flag)
      else $error("second axis result not marked last");

endmodule
